>>> hw/rtl/zts_pkg.sv
// zero-turn goal steering: shared widths, register indexes, cordic and sqrt step functions
// no dependencies
`default_nettype none

package zts_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int DIST_BITS    = 32;
   localparam int SQRT_STEPS   = DIST_BITS;
   localparam int CRD_W        = 37;
   localparam int ANG_W        = 22;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 31;
   localparam int ANG_SHIFT    = 30 - FRAC_BITS;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ANGLE_LIMIT  = 3'd0,
      REG_SPEED_LIMIT  = 3'd1,
      REG_SPEED_GAIN   = 3'd2,
      REG_TURN_ENABLE  = 3'd3,
      REG_TURN_THRESH  = 3'd4
   } csr_index_type;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic [31:0] ATAN_Q30 [10] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149
   };

   typedef struct packed {
      logic signed [CRD_W-1:0] x;
      logic signed [CRD_W-1:0] y;
      logic signed [ANG_W-1:0] z;
   } cordic_type;

   typedef struct packed {
      logic [63:0]          rem;
      logic [DIST_BITS-1:0] root;
      logic                 sat;
   } sqrt_type;

   // q30 angle rounded to nearest into the working fraction
   function automatic logic [63:0] to_frac(logic [63:0] q30);
      return (q30 + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
   endfunction

   localparam logic [63:0] PI_FULL      = to_frac(PI_Q30);
   localparam logic [63:0] HALF_PI_FULL = to_frac(PI_Q30 / 2);
   localparam logic signed [ANG_W-1:0] PI_ANG      = $signed(PI_FULL[ANG_W-1:0]);
   localparam logic signed [ANG_W-1:0] HALF_PI_ANG = $signed(HALF_PI_FULL[ANG_W-1:0]);

   function automatic logic signed [ANG_W-1:0] atan_frac(int i);
      logic [63:0] v;
      logic [63:0] f;
      if (i < 10) begin
         v = 64'(ATAN_Q30[i]);
      end else if (i <= 30) begin
         v = 64'd1 << (30 - i);
      end else begin
         v = '0;
      end
      f = to_frac(v);
      return $signed(f[ANG_W-1:0]);
   endfunction

   // quadrant fold so the vector starts in the right half plane
   function automatic cordic_type cordic_pre(logic signed [CRD_W-1:0] y,
                                             logic signed [CRD_W-1:0] x);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         if (y >= 0) begin
            c.x = y;
            c.y = -x;
            c.z = HALF_PI_ANG;
         end else begin
            c.x = -y;
            c.y = x;
            c.z = -HALF_PI_ANG;
         end
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, int i);
      logic signed [CRD_W-1:0] xs;
      logic signed [CRD_W-1:0] ys;
      cordic_type r;
      xs = c.x >>> i;
      ys = c.y >>> i;
      r  = c;
      if (c.y >= 0) begin
         r.x = c.x + ys;
         r.y = c.y - xs;
         r.z = c.z + atan_frac(i);
      end else begin
         r.x = c.x - ys;
         r.y = c.y + xs;
         r.z = c.z - atan_frac(i);
      end
      return r;
   endfunction

   // one result bit of the integer square root, rem holds s - root^2
   function automatic sqrt_type sqrt_step(sqrt_type s, int i);
      logic [65:0] t;
      sqrt_type r;
      t = ({34'd0, s.root} << (i + 1)) + (66'd1 << (2 * i));
      r = s;
      if ({2'b00, s.rem} >= t) begin
         r.rem  = s.rem - t[63:0];
         r.root = s.root | (DIST_BITS'(1) << i);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/zts_intf.sv
// zero-turn goal steering: request and response channel interfaces
// depends on nothing
`default_nettype none

interface zts_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] goal_x;
   logic signed [31:0] goal_y;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source(output valid, goal_x, goal_y, pos_x, pos_y,
                  quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink(input valid, goal_x, goal_y, pos_x, pos_y,
                quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface zts_rsp_if;
   logic               valid;
   logic               ready;
   logic [30:0]        linear_drive;
   logic signed [18:0] angular_drive;
   logic [31:0]        goal_distance;
   logic               at_goal;
   logic               turning_in_place;

   modport source(output valid, linear_drive, angular_drive, goal_distance,
                  at_goal, turning_in_place, input ready);
   modport sink(input valid, linear_drive, angular_drive, goal_distance,
                at_goal, turning_in_place, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/zero_turn_goal_steering_unit.sv
// zero-turn goal steering top level: distance, yaw, bearing and drive commands
// depends on zts_pkg and the channel interfaces in zts_intf.sv
`default_nettype none

//  channel   direction  contents
//  req       in         goal point, position, orientation quaternion
//  rsp       out        linear and angular drive, distance, status flags
//  csr       in         write enable, register index, write data
//
//  one transaction per cycle while rsp is not stalled; rsp becomes valid once the req transaction
//  passes 38 register stages: 3 front, 32 square root stages carrying both cordic lanes, 3 back
//  the square root stage chain sets the latency
//  when rsp is stalled every stage holds, so nothing is dropped or repeated
//  reset clears valid bits and loads the register defaults

module zero_turn_goal_steering_unit
   import zts_pkg::*;
(
   input  wire                  clock,
   input  wire                  reset,
   zts_req_if.sink              req,
   zts_rsp_if.source            rsp,
   input  wire                  csr_wr_en,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [17:0] angle_limit_ff;
   logic [30:0] speed_limit_ff;
   logic [20:0] speed_gain_ff;
   logic        turn_enable_ff;
   logic [17:0] turn_thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_limit_ff <= 18'd32768;
         speed_limit_ff <= 31'd32768;
         speed_gain_ff  <= 21'd13107;
         turn_enable_ff <= 1'b1;
         turn_thresh_ff <= 18'd3277;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_ANGLE_LIMIT: angle_limit_ff <= csr_wdata[17:0];
            REG_SPEED_LIMIT: speed_limit_ff <= csr_wdata[30:0];
            REG_SPEED_GAIN:  speed_gain_ff  <= csr_wdata[20:0];
            REG_TURN_ENABLE: turn_enable_ff <= csr_wdata[0];
            REG_TURN_THRESH: turn_thresh_ff <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   logic rsp_vld_ff;
   logic adv;

   assign adv       = !rsp_vld_ff || rsp.ready;
   assign req.ready = adv;

   // stage a: differences and quaternion products
   logic               a_vld_ff;
   logic signed [32:0] dx_a_ff, dy_a_ff;
   logic signed [31:0] qwz_a_ff, qxy_a_ff, qyy_a_ff, qzz_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_a_ff  <= 33'(req.goal_x) - 33'(req.pos_x);
         dy_a_ff  <= 33'(req.goal_y) - 33'(req.pos_y);
         qwz_a_ff <= req.quat_w * req.quat_z;
         qxy_a_ff <= req.quat_x * req.quat_y;
         qyy_a_ff <= req.quat_y * req.quat_y;
         qzz_a_ff <= req.quat_z * req.quat_z;
      end
   end

   // stage b: squares of the magnitudes, yaw vector terms
   logic               b_vld_ff;
   logic signed [32:0] dx_b_ff, dy_b_ff;
   logic [63:0]        ax2_b_ff, ay2_b_ff;
   logic signed [33:0] sinp_b_ff, cosp_b_ff;
   logic [32:0]        ax_in, ay_in;
   logic signed [33:0] sinp_in, cosp_in;

   always_comb begin
      ax_in   = dx_a_ff[32] ? 33'(-dx_a_ff) : 33'(dx_a_ff);
      ay_in   = dy_a_ff[32] ? 33'(-dy_a_ff) : 33'(dy_a_ff);
      sinp_in = (34'(qwz_a_ff) + 34'(qxy_a_ff)) <<< 1;
      cosp_in = (34'sd1 <<< 28) - ((34'(qyy_a_ff) + 34'(qzz_a_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   // differences never exceed 2^32 - 1 in magnitude, so 32 bits hold them
   always_ff @(posedge clock) begin
      if (adv) begin
         dx_b_ff   <= dx_a_ff;
         dy_b_ff   <= dy_a_ff;
         ax2_b_ff  <= ax_in[31:0] * ax_in[31:0];
         ay2_b_ff  <= ay_in[31:0] * ay_in[31:0];
         sinp_b_ff <= sinp_in;
         cosp_b_ff <= cosp_in;
      end
   end

   // stage c plus square root chain; cordic lanes ride along
   logic       d_vld_ff [0:SQRT_STEPS];
   sqrt_type   sq_ff    [0:SQRT_STEPS];
   cordic_type yaw_ff   [0:SQRT_STEPS];
   cordic_type brg_ff   [0:SQRT_STEPS];
   logic [64:0] sum_in;

   assign sum_in = {1'b0, ax2_b_ff} + {1'b0, ay2_b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQRT_STEPS; k++) d_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         d_vld_ff[0] <= b_vld_ff;
         for (int k = 0; k < SQRT_STEPS; k++) d_vld_ff[k+1] <= d_vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff[0].rem  <= sum_in[63:0];
         sq_ff[0].root <= '0;
         sq_ff[0].sat  <= sum_in[64];
         yaw_ff[0]     <= cordic_pre(CRD_W'(sinp_b_ff), CRD_W'(cosp_b_ff));
         brg_ff[0]     <= cordic_pre(CRD_W'(dy_b_ff), CRD_W'(dx_b_ff));
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_ff[k+1] <= sqrt_step(sq_ff[k], SQRT_STEPS - 1 - k);
            if (k < CORDIC_STEPS) begin
               yaw_ff[k+1] <= cordic_step(yaw_ff[k], k);
               brg_ff[k+1] <= cordic_step(brg_ff[k], k);
            end else begin
               yaw_ff[k+1] <= yaw_ff[k];
               brg_ff[k+1] <= brg_ff[k];
            end
         end
      end
   end

   // stage e: distance and wrapped heading error
   logic                    e_vld_ff;
   logic [DIST_BITS-1:0]    dist_e_ff;
   logic signed [ANG_W-1:0] err_e_ff;
   logic signed [ANG_W-1:0] diff_in, err_in;

   always_comb begin
      diff_in = brg_ff[SQRT_STEPS].z - yaw_ff[SQRT_STEPS].z;
      if (diff_in > PI_ANG) begin
         err_in = diff_in - (PI_ANG <<< 1);
      end else if (diff_in < -PI_ANG) begin
         err_in = diff_in + (PI_ANG <<< 1);
      end else begin
         err_in = diff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dist_e_ff <= sq_ff[SQRT_STEPS].sat ? '1 : sq_ff[SQRT_STEPS].root;
         err_e_ff  <= err_in;
      end
   end

   // stage f: clamp, zero-turn decision, speed product
   logic                 f_vld_ff;
   logic [DIST_BITS-1:0] dist_f_ff;
   logic signed [18:0]   ang_f_ff;
   logic                 turn_f_ff;
   logic                 goal_f_ff;
   logic [52:0]          prod_f_ff;
   logic signed [ANG_W-1:0] lim_in, ang_in, mag_in;

   always_comb begin
      lim_in = $signed(ANG_W'(angle_limit_ff));
      if (err_e_ff > lim_in) begin
         ang_in = lim_in;
      end else if (err_e_ff < -lim_in) begin
         ang_in = -lim_in;
      end else begin
         ang_in = err_e_ff;
      end
      mag_in = err_e_ff[ANG_W-1] ? -err_e_ff : err_e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   // at_goal only when the distance root is zero, that is below one lsb of distance
   always_ff @(posedge clock) begin
      if (adv) begin
         dist_f_ff <= dist_e_ff;
         ang_f_ff  <= ang_in[18:0];
         turn_f_ff <= turn_enable_ff && (mag_in > $signed(ANG_W'(turn_thresh_ff)));
         goal_f_ff <= (dist_e_ff == '0);
         prod_f_ff <= 53'(speed_gain_ff) * 53'(dist_e_ff);
      end
   end

   // stage g: output register
   logic [30:0]        lin_ff;
   logic signed [18:0] ang_ff;
   logic [31:0]        dist_ff;
   logic               goal_ff;
   logic               turn_ff;
   logic [36:0]        speed_in;
   logic [30:0]        lin_in;

   always_comb begin
      speed_in = prod_f_ff[52:FRAC_BITS];
      if (goal_f_ff || turn_f_ff) begin
         lin_in = '0;
      end else if (speed_in > 37'(speed_limit_ff)) begin
         lin_in = speed_limit_ff;
      end else begin
         lin_in = speed_in[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= f_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff  <= lin_in;
         ang_ff  <= goal_f_ff ? '0 : ang_f_ff;
         dist_ff <= dist_f_ff;
         goal_ff <= goal_f_ff;
         turn_ff <= turn_f_ff && !goal_f_ff;
      end
   end

   assign rsp.valid            = rsp_vld_ff;
   assign rsp.linear_drive     = lin_ff;
   assign rsp.angular_drive    = ang_ff;
   assign rsp.goal_distance    = dist_ff;
   assign rsp.at_goal          = goal_ff;
   assign rsp.turning_in_place = turn_ff;

endmodule

`default_nettype wire
